[sv/crgc_pkg.sv]
// Shared types and constants of the reflected CRC generate/check core.
// No dependencies; every other file imports this package.
package crgc_pkg;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 17;
  localparam int MSG_W   = 16;
  localparam int WID_W   = 6;
  localparam int FIELD_W = 32;
  localparam int IDX_W   = 5;
  localparam int Q_DEPTH = 2;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POLY  = 2'd0,
    REG_WIDTH = 2'd1,
    REG_MSG   = 2'd2
  } crgc_reg_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [MSG_W-1:0] msg_bits;
  } crgc_frame_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] msg_mask;
    logic [BYTE_W-1:0] rx_mask;
    logic [IDX_W-1:0]  rx_base;
    logic              mode;
    logic              last;
  } crgc_item_t;

endpackage

[sv/crgc_in_if.sv]
// Input byte channel of the CRC core: valid/ready plus frame byte and mode.
// Depends on crgc_pkg.
interface crgc_in_if;
  import crgc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              mode;
  modport source (output valid, output data_byte, output mode, input ready);
  modport sink (input valid, input data_byte, input mode, output ready);
endinterface

[sv/crgc_out_if.sv]
// Result channel of the CRC core: valid/ready plus CRC value and match flag.
// Depends on crgc_pkg.
interface crgc_out_if;
  import crgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] crc_value;
  logic               crc_ok;
  modport source (output valid, output crc_value, output crc_ok, input ready);
  modport sink (input valid, input crc_value, input crc_ok, output ready);
endinterface

[sv/crgc_front.sv]
// Front end: accepts frame bytes, tracks the frame bit position and tags each bit
// as message, received-CRC or pad. Depends on crgc_pkg and crgc_in_if.
module crgc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  crgc_in_if.sink                  in_ch,
  input  crgc_pkg::crgc_frame_cfg_t cfg,
  input  logic                     q_full,
  output logic                     push,
  output crgc_pkg::crgc_item_t     item
);
  import crgc_pkg::*;

  logic [CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic             mode_r, mode_nxt;

  always_comb begin
    logic [CNT_W:0] p;
    logic [CNT_W:0] msg;
    logic [CNT_W:0] wid;
    logic [CNT_W:0] total;
    logic           mode_now;
    msg      = (CNT_W+1)'(cfg.msg_bits);
    wid      = (CNT_W+1)'(cfg.width);
    mode_now = (bcnt_r == '0) ? in_ch.mode : mode_r;
    item.data_byte = in_ch.data_byte;
    item.mode      = mode_now;
    item.rx_base   = IDX_W'(bcnt_r - CNT_W'(cfg.msg_bits));
    for (int j = 0; j < BYTE_W; j++) begin
      p = {1'b0, bcnt_r} + (CNT_W+1)'(j);
      item.msg_mask[j] = (p < msg);
      item.rx_mask[j]  = mode_now && (p >= msg) && ((p - msg) < wid);
    end
    total     = msg + (mode_now ? wid : '0);
    item.last = (({1'b0, bcnt_r} + (CNT_W+1)'(BYTE_W)) >= total);
    bcnt_nxt  = item.last ? '0 : bcnt_r + CNT_W'(BYTE_W);
    mode_nxt  = mode_now;
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      mode_r <= 1'b0;
    end else if (push) begin
      bcnt_r <= bcnt_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

[sv/crgc_fifo.sv]
// Short queue of tagged byte transactions between front and back end.
// Depends on crgc_pkg.
module crgc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crgc_pkg::crgc_item_t wr_item,
  output logic                 full,
  output logic                 rd_valid,
  output crgc_pkg::crgc_item_t rd_item,
  input  logic                 pop
);
  import crgc_pkg::*;

  localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  crgc_item_t        slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r;

  assign full     = (fill_r == FILL_W'(Q_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_item  = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[sv/crgc_back.sv]
// Back end: runs eight CRC shift steps per byte, gathers received CRC bits and
// holds the frame result in an output register. Depends on crgc_pkg and crgc_out_if.
module crgc_back #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MAX_CRC_WIDTH-1:0] poly,
  input  logic [MAX_CRC_WIDTH-1:0] mask,
  input  logic                     item_valid,
  input  crgc_pkg::crgc_item_t     item,
  output logic                     pop,
  crgc_out_if.source               out_ch
);
  import crgc_pkg::*;

  logic [MAX_CRC_WIDTH-1:0] crc_r, rx_r, crc_nxt, rx_nxt;
  logic [MAX_CRC_WIDTH-1:0] crc_val_r;
  logic                     crc_ok_r;
  logic                     out_valid_r;
  logic [MAX_CRC_WIDTH-1:0] res_crc;
  logic                     res_ok;

  always_comb begin
    logic [MAX_CRC_WIDTH-1:0] c;
    logic [MAX_CRC_WIDTH-1:0] r;
    logic [IDX_W-1:0]         k;
    logic                     fb;
    c = crc_r;
    r = rx_r;
    for (int j = 0; j < BYTE_W; j++) begin
      fb = c[0] ^ item.data_byte[j];
      if (item.msg_mask[j]) begin
        c = ((c >> 1) ^ (fb ? poly : '0)) & mask;
      end
      k = item.rx_base + IDX_W'(j);
      if (item.rx_mask[j]) begin
        r = r | (MAX_CRC_WIDTH'(item.data_byte[j]) << k);
      end
    end
    crc_nxt = c;
    rx_nxt  = r;
    res_crc = c & mask;
    res_ok  = item.mode ? (res_crc == (r & mask)) : 1'b1;
  end

  // hold a finished frame until the result register is free or being taken
  assign pop = item_valid && (!item.last || !out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.crc_value = FIELD_W'(crc_val_r);
  assign out_ch.crc_ok    = crc_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        crc_r <= item.last ? '0 : crc_nxt;
        rx_r  <= item.last ? '0 : rx_nxt;
      end
      if (pop && item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      crc_val_r <= res_crc;
      crc_ok_r  <= res_ok;
    end
  end

  a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop && item.last |=> out_valid_r)
    else $error("frame end did not load the result register");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop && item.last |=> (crc_r == '0) && (rx_r == '0))
    else $error("frame state not cleared after frame end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && item_valid && item.last |-> !pop)
    else $error("pending result overwritten");

endmodule

[sv/crc_reflected_generate_check_core.sv]
// Top level of the reflected CRC generate/check core: configuration registers,
// front end, queue and back end. Depends on crgc_pkg, crgc_in_if, crgc_out_if.
//
//   channel  | direction | payload                | handshake
//   in_ch    | in        | data_byte[7:0], mode   | valid/ready
//   out_ch   | out       | crc_value[31:0], crc_ok| valid/ready
//   cfg_*    | in        | cfg_index, cfg_wdata   | cfg_we, no wait
//
// A byte per cycle unless stalled; results appear the cycle after a frame's last pop.
// The eight-step XOR-shift chain in the back end sets the cycle length.
// Reset is synchronous; it restores the register defaults and empties the queue.
// A waiting result stalls the next frame-ending byte and every byte queued behind it.
module crc_reflected_generate_check_core #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [crgc_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [crgc_pkg::FIELD_W-1:0]           cfg_wdata,
  crgc_in_if.sink                                in_ch,
  crgc_out_if.source                             out_ch
);
  import crgc_pkg::*;

  logic [FIELD_W-1:0]       poly_r;
  logic [WID_W-1:0]         width_r;
  logic [MSG_W-1:0]         msg_r;
  logic [WID_W-1:0]         w_eff;
  logic [MAX_CRC_WIDTH-1:0] mask;
  logic [MAX_CRC_WIDTH-1:0] poly_m;
  crgc_frame_cfg_t          fcfg;
  crgc_item_t               push_item, q_item;
  logic                     push, q_full, q_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= 32'hEDB8_8320;
      width_r <= WID_W'(32);
      msg_r   <= MSG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLY:  poly_r  <= cfg_wdata;
        REG_WIDTH: width_r <= cfg_wdata[WID_W-1:0];
        REG_MSG:   msg_r   <= cfg_wdata[MSG_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_CRC_WIDTH)) begin
      w_eff = WID_W'(MAX_CRC_WIDTH);
    end else begin
      w_eff = width_r;
    end
    for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
      mask[i] = (WID_W'(i) < w_eff);
    end
    poly_m        = poly_r[MAX_CRC_WIDTH-1:0] & mask;
    fcfg.width    = w_eff;
    fcfg.msg_bits = (msg_r == '0) ? MSG_W'(1) : msg_r;
  end

  crgc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (fcfg),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  crgc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (push_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .pop      (pop)
  );

  crgc_back #(
    .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .poly       (poly_m),
    .mask       (mask),
    .item_valid (q_valid),
    .item       (q_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[bench/crgc_crc_checker.sv]
// Checker for the reflected CRC core: predicts each frame's CRC and match flag
// from observed transactions and compares results. Depends on crgc_pkg, crgc_in_if
// and crgc_out_if.
module crgc_crc_checker #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crgc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [crgc_pkg::FIELD_W-1:0]   cfg_wdata,
  crgc_in_if                             in_ch,
  crgc_out_if                            out_ch,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import crgc_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] crc_value;
    logic               crc_ok;
  } crc_result_t;

  crc_result_t        crc_expected_q[$];
  crc_result_t        crc_exp;
  logic [FIELD_W-1:0] poly_r;
  logic [WID_W-1:0]   width_r;
  logic [MSG_W-1:0]   msg_r;
  logic [FIELD_W-1:0] crc_acc;
  logic [FIELD_W-1:0] rx_crc;
  logic [CNT_W-1:0]   bits_seen;
  logic               frame_chk;
  int                 err_cnt = 0;

  assign errors = err_cnt;

  task automatic crc_shift_byte(input logic [BYTE_W-1:0] b, input logic m);
    int                 w;
    int                 msgn;
    int                 p;
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] poly;
    logic               fb;
    w = (width_r == 0) ? 1 : ((width_r > MAX_CRC_WIDTH) ? MAX_CRC_WIDTH : int'(width_r));
    mask = 32'((64'd1 << w) - 64'd1);
    poly = poly_r & mask;
    msgn = (msg_r == 0) ? 1 : int'(msg_r);
    if (bits_seen == 0) frame_chk = m;
    for (int j = 0; j < BYTE_W; j++) begin
      p = int'(bits_seen);
      if (p < msgn) begin
        fb = crc_acc[0] ^ b[j];
        crc_acc = crc_acc >> 1;
        if (fb) crc_acc = crc_acc ^ poly;
        crc_acc = crc_acc & mask;
      end else if (frame_chk && (p - msgn) < w) begin
        rx_crc[p - msgn] = b[j];
      end
      bits_seen = bits_seen + 1'b1;
    end
    if (int'(bits_seen) >= msgn + (frame_chk ? w : 0)) begin
      crc_expected_q.push_back('{crc_value: crc_acc & mask,
                                 crc_ok: frame_chk ? ((crc_acc & mask) == (rx_crc & mask))
                                                   : 1'b1});
      crc_acc   = '0;
      rx_crc    = '0;
      bits_seen = '0;
      frame_chk = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      poly_r    = 32'hEDB8_8320;
      width_r   = 6'd32;
      msg_r     = 16'd64;
      crc_acc   = '0;
      rx_crc    = '0;
      bits_seen = '0;
      frame_chk = 1'b0;
      crc_expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (crc_expected_q.size() == 0) begin
          $error("unexpected result: crc_value %h crc_ok %b", out_ch.crc_value, out_ch.crc_ok);
          err_cnt++;
        end else begin
          crc_exp = crc_expected_q.pop_front();
          if (out_ch.crc_value !== crc_exp.crc_value) begin
            $error("crc_value mismatch: expected %h, actual %h",
                   crc_exp.crc_value, out_ch.crc_value);
            err_cnt++;
          end
          if (out_ch.crc_ok !== crc_exp.crc_ok) begin
            $error("crc_ok mismatch: expected %b, actual %b", crc_exp.crc_ok, out_ch.crc_ok);
            err_cnt++;
          end
        end
      end
      if (cfg_we) begin
        case (crgc_reg_t'(cfg_index))
          REG_POLY:  poly_r = cfg_wdata;
          REG_WIDTH: width_r = cfg_wdata[WID_W-1:0];
          REG_MSG:   msg_r = cfg_wdata[MSG_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) crc_shift_byte(in_ch.data_byte, in_ch.mode);
    end
    pending <= crc_expected_q.size();
  end

endmodule

[bench/tb_crc_reflected_generate_check_core.sv]
// Testbench top for crc_reflected_generate_check_core: clock, reset, frame and
// configuration stimulus, result back-pressure and verdict. Depends on crgc_pkg,
// crgc_in_if, crgc_out_if and crgc_crc_checker.
module tb_crc_reflected_generate_check_core;
  timeunit 1ns;
  timeprecision 1ps;
  import crgc_pkg::*;

  localparam int MAX_CRC_WIDTH = 32;
  localparam int RANDOM_BYTES  = 1700;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 26;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_wdata;
  int                   errors;
  int                   pending;
  int                   cycles;

  logic [FIELD_W-1:0]   cur_poly;
  logic [WID_W-1:0]     cur_w;
  logic [MSG_W-1:0]     cur_msg;
  int                   open_bits;
  logic                 open_chk;
  int                   bytes_sent;
  logic                 no_idle;
  logic                 hold_req;
  int                   hold_left;
  logic                 hold_taken;

  crgc_in_if  in_ch ();
  crgc_out_if out_ch ();

  crc_reflected_generate_check_core #(
    .MAX_CRC_WIDTH(MAX_CRC_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  crgc_crc_checker #(
    .MAX_CRC_WIDTH(MAX_CRC_WIDTH)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_w();
    return (cur_w == 0) ? 1 : ((cur_w > MAX_CRC_WIDTH) ? MAX_CRC_WIDTH : int'(cur_w));
  endfunction

  function automatic int eff_msg();
    return (cur_msg == 0) ? 1 : int'(cur_msg);
  endfunction

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic m);
    int need;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.mode      <= m;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (open_bits == 0) open_chk = m;
    open_bits += BYTE_W;
    need = eff_msg() + (open_chk ? eff_w() : 0);
    if (open_bits >= need) open_bits = 0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input crgc_reg_t idx, input logic [FIELD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_POLY:  cur_poly = val;
      REG_WIDTH: cur_w = val[WID_W-1:0];
      REG_MSG:   cur_msg = val[MSG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_cfg(input logic [FIELD_W-1:0] poly, input logic [WID_W-1:0] w,
                         input logic [MSG_W-1:0] msg);
    logic [FIELD_W-1:0] wval;
    logic [FIELD_W-1:0] mval;
    wval = $urandom;
    wval[WID_W-1:0] = w;
    mval = $urandom;
    mval[MSG_W-1:0] = msg;
    write_reg(REG_POLY, poly);
    write_reg(REG_WIDTH, wval);
    write_reg(REG_MSG, mval);
    cfg_we <= 1'b0;
  endtask

  task automatic flush_open();
    while (open_bits != 0) send_byte(8'($urandom), 1'($urandom));
  endtask

  // one frame from a fresh boundary; check frames carry the true or a corrupted CRC
  task automatic run_frame(input logic chk, input logic good);
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] poly;
    logic [FIELD_W-1:0] crc;
    logic [FIELD_W-1:0] tail;
    logic [FIELD_W-1:0] flip;
    logic [BYTE_W-1:0]  b;
    logic               fb;
    int                 w;
    int                 m;
    int                 nb;
    int                 p;
    w = eff_w();
    m = eff_msg();
    mask = 32'((64'd1 << w) - 64'd1);
    poly = cur_poly & mask;
    crc = '0;
    tail = '0;
    flip = $urandom & mask;
    if (flip == 0) flip = 32'd1;
    nb = (m + (chk ? w : 0) + BYTE_W - 1) / BYTE_W;
    for (int k = 0; k < nb; k++) begin
      b = 8'($urandom);
      for (int j = 0; j < BYTE_W; j++) begin
        p = k * BYTE_W + j;
        if (p < m) begin
          fb = crc[0] ^ b[j];
          crc = crc >> 1;
          if (fb) crc = crc ^ poly;
        end else if (chk && (p - m) < w) begin
          if (p == m) tail = good ? crc : (crc ^ flip);
          b[j] = tail[p - m];
        end
      end
      send_byte(b, (k == 0) ? chk : 1'($urandom));
    end
  endtask

  task automatic random_cfg();
    logic [WID_W-1:0]   w;
    logic [MSG_W-1:0]   msg;
    logic [FIELD_W-1:0] poly;
    case ($urandom_range(9))
      0: w = 6'd1;
      1: w = 6'd32;
      2: w = 6'($urandom_range(0, 63));
      default: w = 6'($urandom_range(1, 32));
    endcase
    case ($urandom_range(9))
      0: msg = 16'd0;
      1, 2: msg = 16'($urandom_range(65, 400));
      default: msg = 16'($urandom_range(1, 64));
    endcase
    case ($urandom_range(9))
      0: poly = '0;
      1: poly = '1;
      default: poly = $urandom;
    endcase
    set_cfg(poly, w, msg);
  endtask

  initial begin
    int base;
    int budget;
    int phase_start;
    int phase;
    int r;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_POLY;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.mode      <= 1'b0;
    no_idle         <= 1'b0;
    hold_req        <= 1'b0;
    cur_poly   = 32'hEDB8_8320;
    cur_w      = 6'd32;
    cur_msg    = 16'd64;
    open_bits  = 0;
    open_chk   = 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    run_frame(1'b0, 1'b1);
    settle();

    // byte-wide CRC, all-ones and all-zeros bytes, good and bad checks
    set_cfg(32'h0000_00E0, 6'd8, 16'd8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    run_frame(1'b1, 1'b1);
    run_frame(1'b1, 1'b0);
    settle();

    // zero width and zero length, over-wide polynomial
    set_cfg(32'hFFFF_FFFF, 6'd0, 16'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFE, 1'b1);
    settle();

    // width beyond the maximum
    set_cfg($urandom, 6'd63, 16'd1);
    run_frame(1'b1, 1'b1);
    settle();

    // shorten the frame under a partly received one
    set_cfg(32'hEDB8_8320, 6'd32, 16'd64);
    repeat (3) send_byte(8'($urandom), 1'b0);
    settle();
    write_reg(REG_MSG, 32'd8);
    cfg_we <= 1'b0;
    send_byte(8'($urandom), 1'($urandom));
    settle();

    base = bytes_sent;
    phase = 0;
    while (bytes_sent - base < RANDOM_BYTES) begin
      no_idle <= (phase == 2);
      if (phase == 4) begin
        set_cfg($urandom, 6'd8, 16'd8);
        hold_req <= 1'b1;
      end else begin
        random_cfg();
      end
      budget = $urandom_range(150, 250);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < budget) begin
        flush_open();
        r = $urandom_range(99);
        if (r < 45) run_frame(1'b1, 1'b1);
        else if (r < 70) run_frame(1'b0, 1'b1);
        else if (r < 85) run_frame(1'b1, 0);
        else repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
      end
      settle();
      phase++;
    end

    // longest message setting in check mode, then shorten it under the open frame
    no_idle <= 1'b0;
    set_cfg($urandom, 6'd32, 16'hFFFF);
    flush_open();
    repeat (16) send_byte(8'($urandom), 1'b1);
    settle();
    write_reg(REG_MSG, 32'd200);
    cfg_we <= 1'b0;
    flush_open();
    settle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
